FILE: rtl/voice_slot_allocator_macros.svh
// Assertion macros for the voice slot allocator.
`ifndef VOICE_SLOT_ALLOCATOR_MACROS_SVH
`define VOICE_SLOT_ALLOCATOR_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define VSA_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("voice_slot_allocator: check failed");
// Same check, also active during reset.
`define VSA_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("voice_slot_allocator: check failed");
`endif

FILE: rtl/vsa_pkg.sv
// Shared types and constants for the voice slot allocator.
package vsa_pkg;
  localparam int unsigned VoiceSlots = 32;
  localparam int unsigned SlotW = $clog2(VoiceSlots);
  localparam int unsigned CntW = $clog2(VoiceSlots + 1);

  localparam logic [1:0] ST_FREE = 2'd0;
  localparam logic [1:0] ST_ACTIVE = 2'd1;
  localparam logic [1:0] ST_RELEASING = 2'd2;
  localparam logic [1:0] ST_FINISHED = 2'd3;

  localparam logic [2:0] REQ_NOTE_ON = 3'd0;
  localparam logic [2:0] REQ_NOTE_OFF = 3'd1;
  localparam logic [2:0] REQ_PEDAL = 3'd2;
  localparam logic [2:0] REQ_ALL_OFF = 3'd3;
  localparam logic [2:0] REQ_RESET = 3'd4;
  localparam logic [2:0] REQ_FINISHED = 3'd5;

  localparam logic CFG_GENERATION = 1'b0;
  localparam logic CFG_POLICY = 1'b1;

  // One slot entry as held in the table memory.
  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  note;
    logic [15:0] generation;
    logic [31:0] voice_num;
    logic        deferred;
    logic        ignore_off;
  } slot_t;

  // Memory port between control and table.
  typedef struct packed {
    logic             rd_en;
    logic [SlotW-1:0] rd_addr;
    logic             wr_en;
    logic [SlotW-1:0] wr_addr;
    slot_t            wr_data;
  } mem_req_t;
endpackage

FILE: rtl/vsa_table.sv
// Slot table memory, one read and one write port, registered read data.
module vsa_table (
  input  logic            clk_i,
  input  vsa_pkg::mem_req_t req_i,
  output vsa_pkg::slot_t  rd_data_o
);
  import vsa_pkg::*;
  slot_t mem_q [VoiceSlots];

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) mem_q[req_i.wr_addr] <= req_i.wr_data;
    if (req_i.rd_en) rd_data_o <= mem_q[req_i.rd_addr];
  end
endmodule

FILE: rtl/vsa_ctrl.sv
// Request sequencer: scans the slot table, modifies and writes entries back.
module vsa_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [2:0]              req_type_i,
  input  logic [6:0]              note_i,
  input  logic                    pedal_pressed_i,
  input  logic                    ignores_note_off_i,
  input  logic [4:0]              finished_slot_i,
  input  logic [15:0]             active_generation_i,
  input  logic                    performance_policy_i,
  input  logic                    out_taken_i,
  output logic                    busy_o,
  output logic                    out_valid_o,
  output logic [4:0]              slot_index_o,
  output logic [31:0]             voice_id_o,
  output logic                    stolen_o,
  output logic                    generation_stolen_o,
  output logic                    releasing_stolen_o,
  output logic [5:0]              affected_count_o,
  output logic                    dropped_o,
  output logic [5:0]              active_count_o,
  output logic [5:0]              releasing_count_o,
  output logic [5:0]              deferred_count_o,
  output vsa_pkg::mem_req_t       mem_o,
  input  vsa_pkg::slot_t          rd_data_i
);
  import vsa_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;  // read every slot, modify, write back
  localparam logic [2:0] S_PICK = 3'd2;  // note_on: write the chosen slot
  localparam logic [2:0] S_OUT = 3'd3;

  logic [2:0] state_q, state_d;
  logic [SlotW:0] rd_ptr_q, rd_ptr_d;   // address issued; one ahead of data
  logic rd_vld_q, rd_vld_d;
  logic [SlotW-1:0] dat_idx_q, dat_idx_d;
  logic [2:0] type_q;
  logic [6:0] note_q;
  logic ign_q, press_q, pedal_q, pedal_d, pedal_old_q;
  logic [4:0] fin_q;
  logic [31:0] next_vid_q, next_vid_d;
  logic [CntW-1:0] n_act_q, n_act_d, n_rel_q, n_rel_d, n_def_q, n_def_d;
  logic [CntW-1:0] aff_q, aff_d;
  logic free_hit_q, free_hit_d;
  logic [SlotW-1:0] sel_q, sel_d;
  logic [1:0] br_q, br_d;
  logic [15:0] bg_q, bg_d;
  logic [31:0] bv_q, bv_d;
  logic bret_q, bret_d, brel_q, brel_d;
  logic out_valid_q, out_valid_d;
  slot_t ent, nxt;
  logic wr_en;
  logic retired, is_rel, better;
  logic [1:0] rank;

  assign ent = rd_data_i;
  assign retired = ent.generation != active_generation_i;
  assign is_rel = ent.status == ST_RELEASING;
  always_comb begin
    if (performance_policy_i) rank = is_rel ? (retired ? 2'd2 : 2'd3)
                                            : (retired ? 2'd0 : 2'd1);
    else rank = is_rel ? 2'd0 : 2'd1;
  end
  assign better = (dat_idx_q == '0) || (rank < br_q) ||
                  (rank == br_q && ent.generation < bg_q) ||
                  (rank == br_q && ent.generation == bg_q && ent.voice_num < bv_q);

  always_comb begin
    state_d = state_q;
    rd_ptr_d = rd_ptr_q;
    rd_vld_d = 1'b0;
    dat_idx_d = dat_idx_q;
    pedal_d = pedal_q;
    next_vid_d = next_vid_q;
    n_act_d = n_act_q; n_rel_d = n_rel_q; n_def_d = n_def_q;
    aff_d = aff_q;
    free_hit_d = free_hit_q;
    sel_d = sel_q; br_d = br_q; bg_d = bg_q; bv_d = bv_q;
    bret_d = bret_q; brel_d = brel_q;
    out_valid_d = out_valid_q;
    nxt = ent;
    wr_en = 1'b0;
    mem_o = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_SCAN;
          rd_ptr_d = '0;
          n_act_d = '0; n_rel_d = '0; n_def_d = '0; aff_d = '0;
          free_hit_d = 1'b0;
          sel_d = '0;
          if (req_type_i == REQ_PEDAL && pedal_pressed_i != pedal_q) pedal_d = pedal_pressed_i;
          if (req_type_i == REQ_RESET) pedal_d = 1'b0;
        end
      end
      S_SCAN: begin
        if (rd_ptr_q < (SlotW+1)'(VoiceSlots)) begin
          mem_o.rd_en = 1'b1;
          mem_o.rd_addr = rd_ptr_q[SlotW-1:0];
          rd_ptr_d = rd_ptr_q + 1'b1;
          rd_vld_d = 1'b1;
          dat_idx_d = rd_ptr_q[SlotW-1:0];
        end
        if (rd_vld_q) begin
          case (type_q)
            REQ_NOTE_ON: begin
              if (!free_hit_q) begin
                if (ent.status == ST_FREE || ent.status == ST_FINISHED) begin
                  free_hit_d = 1'b1;
                  sel_d = dat_idx_q;
                  bret_d = 1'b0; brel_d = 1'b0;
                end else if (better) begin
                  sel_d = dat_idx_q; br_d = rank;
                  bg_d = ent.generation; bv_d = ent.voice_num;
                  bret_d = retired; brel_d = is_rel;
                end
              end
            end
            REQ_NOTE_OFF: begin
              if (ent.status == ST_ACTIVE && ent.note == note_q) begin
                wr_en = 1'b1;
                if (ent.ignore_off) nxt.deferred = 1'b0;
                else if (pedal_q) nxt.deferred = 1'b1;
                else begin
                  nxt.status = ST_RELEASING; nxt.deferred = 1'b0; aff_d = aff_d + 1'b1;
                end
              end
            end
            REQ_PEDAL: begin
              if (press_q != pedal_old_q && !press_q &&
                  ent.status == ST_ACTIVE && ent.deferred) begin
                wr_en = 1'b1;
                nxt.status = ST_RELEASING; nxt.deferred = 1'b0; aff_d = aff_d + 1'b1;
              end
            end
            REQ_ALL_OFF: begin
              if (ent.status == ST_ACTIVE) begin
                wr_en = 1'b1;
                nxt.status = ST_RELEASING; nxt.deferred = 1'b0; aff_d = aff_d + 1'b1;
              end
            end
            REQ_RESET: begin
              wr_en = 1'b1;
              if (ent.status == ST_ACTIVE || ent.status == ST_RELEASING) aff_d = aff_d + 1'b1;
              nxt.status = ST_FREE; nxt.deferred = 1'b0;
            end
            REQ_FINISHED: begin
              if (5'(dat_idx_q) == fin_q &&
                  (ent.status == ST_ACTIVE || ent.status == ST_RELEASING)) begin
                wr_en = 1'b1;
                nxt.status = ST_FINISHED; nxt.deferred = 1'b0;
              end
            end
            default: ;
          endcase
          // counts after modification; note_on fixes them up in S_PICK
          if (nxt.status == ST_ACTIVE) begin
            n_act_d = n_act_d + 1'b1;
            if (nxt.deferred) n_def_d = n_def_d + 1'b1;
          end else if (nxt.status == ST_RELEASING) n_rel_d = n_rel_d + 1'b1;
          mem_o.wr_en = wr_en;
          mem_o.wr_addr = dat_idx_q;
          mem_o.wr_data = nxt;
          if (dat_idx_q == SlotW'(VoiceSlots - 1))
            state_d = (type_q == REQ_NOTE_ON) ? S_PICK : S_OUT;
        end
      end
      S_PICK: begin
        // old entry of the chosen slot leaves the counts, the new voice joins
        mem_o.wr_en = 1'b1;
        mem_o.wr_addr = sel_q;
        mem_o.wr_data.status = ST_ACTIVE;
        mem_o.wr_data.note = note_q;
        mem_o.wr_data.generation = active_generation_i;
        mem_o.wr_data.voice_num = next_vid_q;
        mem_o.wr_data.deferred = 1'b0;
        mem_o.wr_data.ignore_off = ign_q;
        n_act_d = n_act_q + 1'b1;
        if (!free_hit_q) begin
          if (brel_q) n_rel_d = n_rel_q - 1'b1;
          else begin
            n_act_d = n_act_q;
          end
        end
        next_vid_d = (next_vid_q == 32'hFFFF_FFFF) ? 32'd1 : next_vid_q + 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q) out_valid_d = 1'b1;
        else if (out_taken_i) begin
          out_valid_d = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Stolen active slots may have been deferred; this flag feeds the n_def drop in S_PICK.
  logic sel_def_q;
  always_ff @(posedge clk_i) begin
    if (state_q == S_SCAN && rd_vld_q && type_q == REQ_NOTE_ON && !free_hit_q) begin
      if ((ent.status == ST_FREE || ent.status == ST_FINISHED) || better)
        sel_def_q <= (ent.status == ST_ACTIVE) && ent.deferred;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rd_ptr_q <= '0;
      rd_vld_q <= 1'b0;
      pedal_q <= 1'b0;
      next_vid_q <= 32'd1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_ptr_q <= rd_ptr_d;
      rd_vld_q <= rd_vld_d;
      pedal_q <= pedal_d;
      next_vid_q <= next_vid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dat_idx_q <= dat_idx_d;
    aff_q <= aff_d;
    free_hit_q <= free_hit_d;
    sel_q <= sel_d; br_q <= br_d; bg_q <= bg_d; bv_q <= bv_d;
    bret_q <= bret_d; brel_q <= brel_d;
    n_act_q <= n_act_d; n_rel_q <= n_rel_d;
    if (state_q == S_PICK && !free_hit_q && !brel_q && sel_def_q)
      n_def_q <= n_def_q - 1'b1;
    else n_def_q <= n_def_d;
    if (state_q == S_IDLE && start_i) begin
      type_q <= req_type_i;
      note_q <= note_i;
      ign_q <= ignores_note_off_i;
      press_q <= pedal_pressed_i;
      pedal_old_q <= pedal_q;
      fin_q <= finished_slot_i;
    end
  end

  // Result register, filled on entry to S_OUT.
  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && !out_valid_q) begin
      slot_index_o <= (type_q == REQ_NOTE_ON) ? 5'(sel_q) : 5'd0;
      voice_id_o <= (type_q == REQ_NOTE_ON)
                    ? ((next_vid_q == 32'd1) ? 32'hFFFF_FFFF : next_vid_q - 1'b1) : 32'd0;
      stolen_o <= (type_q == REQ_NOTE_ON) && !free_hit_q;
      generation_stolen_o <= (type_q == REQ_NOTE_ON) && !free_hit_q && bret_q;
      releasing_stolen_o <= (type_q == REQ_NOTE_ON) && !free_hit_q && brel_q;
      affected_count_o <= 6'(aff_q);
      dropped_o <= !(type_q inside {REQ_NOTE_ON, REQ_NOTE_OFF, REQ_PEDAL, REQ_ALL_OFF,
                                    REQ_RESET, REQ_FINISHED});
      active_count_o <= 6'(n_act_q);
      releasing_count_o <= 6'(n_rel_q);
      deferred_count_o <= 6'(n_def_q);
    end
  end

  assign busy_o = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
endmodule

FILE: rtl/voice_slot_allocator.sv
// Voice slot allocator: one result item per request item.
// Each request runs a read-modify-write scan of all 32 slots, then for note_on a
// write of the chosen slot, then a load of the result register.
// No new request is taken until the previous result is accepted; output stall holds it.
// Reset: control, pedal and registers clear at once; a sweep that writes every table
// slot free follows, with input stalled.
module voice_slot_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  req_type_i,
  input  logic [6:0]  note_i,
  input  logic        pedal_pressed_i,
  input  logic        ignores_note_off_i,
  input  logic [4:0]  finished_slot_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  slot_index_o,
  output logic [31:0] voice_id_o,
  output logic        stolen_o,
  output logic        generation_stolen_o,
  output logic        releasing_stolen_o,
  output logic [5:0]  affected_count_o,
  output logic        dropped_o,
  output logic [5:0]  active_count_o,
  output logic [5:0]  releasing_count_o,
  output logic [5:0]  deferred_count_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import vsa_pkg::*;
  `include "voice_slot_allocator_macros.svh"

  logic [15:0] gen_q;
  logic pol_q;
  logic busy, start;
  logic [SlotW:0] clr_q;
  logic clearing;
  mem_req_t ctrl_req, mem_req;
  slot_t rd_data;

  assign clearing = clr_q < (SlotW+1)'(VoiceSlots);
  assign start = in_valid_i && !in_stall_o;
  assign in_stall_o = busy || clearing;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q <= '0;
      pol_q <= 1'b0;
      clr_q <= '0;
    end else begin
      if (clearing) clr_q <= clr_q + 1'b1;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_GENERATION: gen_q <= cfg_data_i;
          CFG_POLICY: pol_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    mem_req = ctrl_req;
    if (clearing) begin
      mem_req.wr_en = 1'b1;
      mem_req.wr_addr = clr_q[SlotW-1:0];
      mem_req.wr_data = '0;
    end
  end

  vsa_table u_table (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  vsa_ctrl u_ctrl (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .start_i              (start),
    .req_type_i           (req_type_i),
    .note_i               (note_i),
    .pedal_pressed_i      (pedal_pressed_i),
    .ignores_note_off_i   (ignores_note_off_i),
    .finished_slot_i      (finished_slot_i),
    .active_generation_i  (gen_q),
    .performance_policy_i (pol_q),
    .out_taken_i          (!out_stall_i),
    .busy_o               (busy),
    .out_valid_o          (out_valid_o),
    .slot_index_o         (slot_index_o),
    .voice_id_o           (voice_id_o),
    .stolen_o             (stolen_o),
    .generation_stolen_o  (generation_stolen_o),
    .releasing_stolen_o   (releasing_stolen_o),
    .affected_count_o     (affected_count_o),
    .dropped_o            (dropped_o),
    .active_count_o       (active_count_o),
    .releasing_count_o    (releasing_count_o),
    .deferred_count_o     (deferred_count_o),
    .mem_o                (ctrl_req),
    .rd_data_i            (rd_data)
  );

  `VSA_ASSERT(a_no_accept_when_busy, clk_i, rst_ni, (busy || clearing) |-> !start)
  `VSA_ASSERT(a_out_only_when_busy, clk_i, rst_ni, out_valid_o |-> busy)
  `VSA_ASSERT(a_clear_no_ctrl_write, clk_i, rst_ni, clearing |-> !ctrl_req.wr_en)
endmodule

FILE: tb/tb_top.sv
// Testbench for the voice slot allocator: random and directed requests, scoreboard checking.
module tb_top;
  import vsa_pkg::*;

  localparam int unsigned SlotCnt = 32;
  localparam logic [2:0] REQ_DROP_A = 3'd6;
  localparam logic [2:0] REQ_DROP_B = 3'd7;

  typedef struct packed {
    logic [4:0]  slot_index;
    logic [31:0] voice_id;
    logic        stolen;
    logic        generation_stolen;
    logic        releasing_stolen;
    logic [5:0]  affected_count;
    logic        dropped;
    logic [5:0]  active_count;
    logic [5:0]  releasing_count;
    logic [5:0]  deferred_count;
  } alloc_result_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic [6:0] note;
    logic       pedal_pressed;
    logic       ignores_note_off;
    logic [4:0] finished_slot;
  } alloc_req_t;

  // Shadow of the slot table; predicts one result per request.
  class voice_table_sb;
    logic [1:0]  status[SlotCnt];
    logic [6:0]  note_of[SlotCnt];
    logic [15:0] gen_of[SlotCnt];
    logic [31:0] vnum_of[SlotCnt];
    logic        defer_of[SlotCnt];
    logic        ign_of[SlotCnt];
    logic        pedal;
    logic [31:0] next_vnum;
    logic [15:0] cur_gen;
    logic        perf_policy;
    alloc_result_t pending[$];
    int          errors;
    int          checked;
    int          steals;

    function new();
      for (int i = 0; i < SlotCnt; i++) begin
        status[i] = ST_FREE; note_of[i] = '0; gen_of[i] = '0;
        vnum_of[i] = '0; defer_of[i] = 0; ign_of[i] = 0;
      end
      pedal = 0; next_vnum = 1; cur_gen = '0; perf_policy = 0;
      errors = 0; checked = 0; steals = 0;
    endfunction

    function int unsigned rank_of(int i);
      logic retired, rel;
      retired = gen_of[i] != cur_gen;
      rel = status[i] == ST_RELEASING;
      if (perf_policy) return rel ? (retired ? 2 : 3) : (retired ? 0 : 1);
      return rel ? 0 : 1;
    endfunction

    function void note_request(alloc_req_t rq);
      alloc_result_t r;
      int sel, br, bg;
      logic [31:0] bv;
      int affected, na, nr, nd;
      r = '0; affected = 0;
      case (rq.req_type)
        REQ_NOTE_ON: begin
          sel = -1;
          for (int i = 0; i < SlotCnt; i++)
            if (sel < 0 && (status[i] == ST_FREE || status[i] == ST_FINISHED)) sel = i;
          if (sel < 0) begin
            sel = 0; br = 0; bg = 0; bv = '0;
            for (int i = 0; i < SlotCnt; i++) begin
              int rk;
              rk = rank_of(i);
              if (i == 0 || rk < br || (rk == br && gen_of[i] < bg) ||
                  (rk == br && gen_of[i] == bg && vnum_of[i] < bv)) begin
                sel = i; br = rk; bg = gen_of[i]; bv = vnum_of[i];
              end
            end
            r.stolen = 1;
            r.generation_stolen = gen_of[sel] != cur_gen;
            r.releasing_stolen = status[sel] == ST_RELEASING;
            steals++;
          end
          status[sel] = ST_ACTIVE; note_of[sel] = rq.note; gen_of[sel] = cur_gen;
          vnum_of[sel] = next_vnum; defer_of[sel] = 0; ign_of[sel] = rq.ignores_note_off;
          r.voice_id = next_vnum;
          r.slot_index = sel[4:0];
          next_vnum++;
          if (next_vnum == 0) next_vnum = 1;
        end
        REQ_NOTE_OFF:
          for (int i = 0; i < SlotCnt; i++) begin
            if (status[i] != ST_ACTIVE || note_of[i] != rq.note) continue;
            if (ign_of[i]) defer_of[i] = 0;
            else if (pedal) defer_of[i] = 1;
            else begin status[i] = ST_RELEASING; defer_of[i] = 0; affected++; end
          end
        REQ_PEDAL:
          if (rq.pedal_pressed != pedal) begin
            pedal = rq.pedal_pressed;
            if (!pedal)
              for (int i = 0; i < SlotCnt; i++)
                if (status[i] == ST_ACTIVE && defer_of[i]) begin
                  status[i] = ST_RELEASING; defer_of[i] = 0; affected++;
                end
          end
        REQ_ALL_OFF:
          for (int i = 0; i < SlotCnt; i++)
            if (status[i] == ST_ACTIVE) begin
              status[i] = ST_RELEASING; defer_of[i] = 0; affected++;
            end
        REQ_RESET: begin
          for (int i = 0; i < SlotCnt; i++) begin
            if (status[i] == ST_ACTIVE || status[i] == ST_RELEASING) affected++;
            status[i] = ST_FREE; defer_of[i] = 0;
          end
          pedal = 0;
        end
        REQ_FINISHED:
          if (status[rq.finished_slot] == ST_ACTIVE ||
              status[rq.finished_slot] == ST_RELEASING) begin
            status[rq.finished_slot] = ST_FINISHED; defer_of[rq.finished_slot] = 0;
          end
        default: r.dropped = 1;
      endcase
      na = 0; nr = 0; nd = 0;
      for (int i = 0; i < SlotCnt; i++)
        if (status[i] == ST_ACTIVE) begin
          na++; if (defer_of[i]) nd++;
        end else if (status[i] == ST_RELEASING) nr++;
      r.affected_count = affected[5:0];
      r.active_count = na[5:0];
      r.releasing_count = nr[5:0];
      r.deferred_count = nd[5:0];
      pending.push_back(r);
    endfunction

    function void check_result(alloc_result_t got);
      alloc_result_t exp_r;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected result %p", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        errors++;
        if (errors <= 10) $display("ERROR: result %0d mismatch\n  exp %p\n  got %p",
                                   checked, exp_r, got);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [2:0]  req_type = '0;
  logic [6:0]  note = '0;
  logic        pedal_pressed = 0;
  logic        ignores_note_off = 0;
  logic [4:0]  finished_slot = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [4:0]  slot_index;
  logic [31:0] voice_id;
  logic        stolen, generation_stolen, releasing_stolen, dropped;
  logic [5:0]  affected_count, active_count, releasing_count, deferred_count;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic        cfg_index = 0;
  logic [15:0] cfg_data = '0;

  voice_table_sb sb = new();
  int  idle_pct = 38;
  int  item_cnt = 0;

  always #5 clk = ~clk;

  voice_slot_allocator dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .req_type_i(req_type), .note_i(note), .pedal_pressed_i(pedal_pressed),
    .ignores_note_off_i(ignores_note_off), .finished_slot_i(finished_slot),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .slot_index_o(slot_index), .voice_id_o(voice_id), .stolen_o(stolen),
    .generation_stolen_o(generation_stolen), .releasing_stolen_o(releasing_stolen),
    .affected_count_o(affected_count), .dropped_o(dropped),
    .active_count_o(active_count), .releasing_count_o(releasing_count),
    .deferred_count_o(deferred_count),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  // Receiver: random stall, check on every accepted result.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result('{slot_index, voice_id, stolen, generation_stolen,
                        releasing_stolen, affected_count, dropped, active_count,
                        releasing_count, deferred_count});
    out_stall <= ($urandom_range(99) < idle_pct);
  end

  // Valid stays up after an accept; the block stalls while busy, and the next item is set up meanwhile.
  task automatic send_req(alloc_req_t rq);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    {req_type, note, pedal_pressed, ignores_note_off, finished_slot} <= rq;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(rq);
    item_cnt++;
  endtask

  task automatic write_cfg(logic idx, logic [15:0] val);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_GENERATION) sb.cur_gen = val;
    else sb.perf_policy = val[0];
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic alloc_req_t mk(logic [2:0] t, logic [6:0] n, logic p, logic ig,
                                    logic [4:0] f);
    return '{t, n, p, ig, f};
  endfunction

  // Mostly musical traffic on a small note set so note_off matches and steals happen.
  function automatic alloc_req_t rand_req();
    alloc_req_t rq;
    int k;
    rq = mk(3'($urandom_range(7)), 7'($urandom_range(127)), 1'($urandom_range(1)),
            ($urandom_range(9) == 0), 5'($urandom_range(31)));
    k = $urandom_range(99);
    if (k < 45) rq.req_type = REQ_NOTE_ON;
    else if (k < 70) rq.req_type = REQ_NOTE_OFF;
    else if (k < 78) rq.req_type = REQ_PEDAL;
    else if (k < 90) rq.req_type = REQ_FINISHED;
    else if (k < 93) rq.req_type = REQ_ALL_OFF;
    else if (k < 95) rq.req_type = REQ_RESET;
    if (k < 70 && $urandom_range(3) != 0) rq.note = 7'(60 + $urandom_range(11));
    return rq;
  endfunction

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1;
    write_cfg(CFG_GENERATION, 16'd0);
    write_cfg(CFG_POLICY, 16'd0);
    // Directed: fill the table, steal, pedal deferral, one-shots, odd codes.
    for (int i = 0; i < 33; i++)
      send_req(mk(REQ_NOTE_ON, (i == 0) ? 7'd127 : 7'd0, 1'b0, i == 1, 5'd31));
    send_req(mk(REQ_PEDAL, 7'd0, 1'b1, 1'b0, 5'd0));
    send_req(mk(REQ_PEDAL, 7'd0, 1'b1, 1'b0, 5'd0));
    send_req(mk(REQ_NOTE_OFF, 7'd0, 1'b0, 1'b0, 5'd0));
    send_req(mk(REQ_NOTE_OFF, 7'd127, 1'b0, 1'b0, 5'd0));
    send_req(mk(REQ_PEDAL, 7'd0, 1'b0, 1'b0, 5'd0));
    send_req(mk(REQ_FINISHED, 7'd0, 1'b0, 1'b0, 5'd31));
    send_req(mk(REQ_FINISHED, 7'd0, 1'b0, 1'b0, 5'd31));
    send_req(mk(REQ_ALL_OFF, 7'd0, 1'b0, 1'b0, 5'd0));
    send_req(mk(REQ_DROP_A, 7'h7f, 1'b1, 1'b1, 5'd31));
    send_req(mk(REQ_DROP_B, 7'h00, 1'b0, 1'b0, 5'd0));
    send_req(mk(REQ_RESET, 7'd0, 1'b0, 1'b0, 5'd0));
    drain();
    // Random phases over several register settings, extremes included.
    for (int ph = 0; ph < 6; ph++) begin
      write_cfg(CFG_POLICY, 16'(ph[0]));
      write_cfg(CFG_GENERATION, (ph == 2) ? 16'hffff : (ph == 4) ? 16'h0000 :
                                16'($urandom_range(3)));
      idle_pct = (ph == 3) ? 0 : 38;
      for (int n = 0; n < 180; n++) begin
        if (n == 90) begin
          drain();
          write_cfg(CFG_GENERATION, sb.cur_gen + 16'd1);
        end
        send_req(rand_req());
      end
      drain();
    end
    idle_pct = 38;
    $display("Covered %0d requests, %0d steals, %0d results checked.",
             item_cnt, sb.steals, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #3000000;
    $display("TIMEOUT");
    $display("DONE: errors detected");
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+rtl
rtl/vsa_pkg.sv
rtl/vsa_table.sv
rtl/vsa_ctrl.sv
rtl/voice_slot_allocator.sv
tb/tb_top.sv
